// ===== sv/indexed_max_heap_top_assert.svh =====
// Assertion macros for the indexed max-heap top level.
`ifndef INDEXED_MAX_HEAP_TOP_ASSERT_SVH
`define INDEXED_MAX_HEAP_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define IHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define IHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ihp_pkg.sv =====
`timescale 1ns / 1ps
package ihp_pkg;

  localparam int KEY_W   = 32;
  localparam int VTX_W   = 8;
  localparam int NUM_VTX = 256;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_BUILD    = 2'd1,
    REQ_DELETE   = 2'd2,
    REQ_INCREASE = 2'd3
  } req_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_SMALLER = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VTX_W-1:0]        vtx;
  } slot_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_SET_EMPTY,
    OP_RD0,
    OP_DEL_TOP,
    OP_BUILD_STEP,
    OP_MOV_RD,
    OP_SD_L,
    OP_SD_R,
    OP_SD_C,
    OP_INC_CHK,
    OP_INC_KEY,
    OP_SU,
    OP_SU_C,
    OP_WR_MOV,
    OP_RD_TOP,
    OP_FIN
  } op_e;

  typedef struct packed {
    req_e req;
    logic load_bad;
    logic empty;
    logic one;
    logic build_left;
    logic inc_bad;
    logic inc_smaller;
    logic sd_move;
    logic node_zero;
    logic su_move;
    logic out_free;
  } st_t;

endpackage

// ===== sv/ihp_if.sv =====
`timescale 1ns / 1ps
interface ihp_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            req_type;
  logic [ihp_pkg::VTX_W-1:0]             vertex;
  logic signed [ihp_pkg::KEY_W-1:0]      key;

  modport source (output valid, req_type, vertex, key, input ready);
  modport sink   (input valid, req_type, vertex, key, output ready);
endinterface

interface ihp_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ihp_pkg::VTX_W-1:0]     top_vertex;
  logic [ihp_pkg::COUNT_W-1:0]   count;
  logic                          empty_res;

  modport source (output valid, status, top_vertex, count, empty_res, input ready);
  modport sink   (input valid, status, top_vertex, count, empty_res, output ready);
endinterface

// ===== sv/ihp_ram.sv =====
`timescale 1ns / 1ps
module ihp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ihp_ctrl.sv =====
`timescale 1ns / 1ps
module ihp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ihp_pkg::st_t  st_i,
  output ihp_pkg::op_e  op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DEL_TOP,
    S_MOV,
    S_BUILD,
    S_SD_L,
    S_SD_R,
    S_SD_C,
    S_INC_KEY,
    S_SU,
    S_SU_C,
    S_WRM,
    S_RD_TOP,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence the datapath, issuing at most one operation per cycle
  always_comb begin
    state_d = state_q;
    op_o    = ihp_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = ihp_pkg::OP_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st_i.req)
          ihp_pkg::REQ_LOAD: begin
            op_o    = ihp_pkg::OP_LOAD;
            state_d = S_RD_TOP;
          end
          ihp_pkg::REQ_BUILD: begin
            state_d = S_BUILD;
          end
          ihp_pkg::REQ_DELETE: begin
            if (st_i.empty) begin
              op_o    = ihp_pkg::OP_SET_EMPTY;
              state_d = S_RD_TOP;
            end else begin
              op_o    = ihp_pkg::OP_RD0;
              state_d = S_DEL_TOP;
            end
          end
          default: begin
            op_o    = ihp_pkg::OP_INC_CHK;
            state_d = st_i.inc_bad ? S_RD_TOP : S_INC_KEY;
          end
        endcase
      end
      S_DEL_TOP: begin
        op_o    = ihp_pkg::OP_DEL_TOP;
        state_d = st_i.one ? S_RD_TOP : S_MOV;
      end
      S_MOV: begin
        op_o    = ihp_pkg::OP_MOV_RD;
        state_d = S_SD_L;
      end
      S_BUILD: begin
        if (st_i.build_left) begin
          op_o    = ihp_pkg::OP_BUILD_STEP;
          state_d = S_MOV;
        end else begin
          state_d = S_RD_TOP;
        end
      end
      S_SD_L: begin
        op_o    = ihp_pkg::OP_SD_L;
        state_d = S_SD_R;
      end
      S_SD_R: begin
        op_o    = ihp_pkg::OP_SD_R;
        state_d = S_SD_C;
      end
      S_SD_C: begin
        op_o = ihp_pkg::OP_SD_C;
        if (st_i.sd_move) begin
          state_d = S_SD_L;
        end else if (st_i.req == ihp_pkg::REQ_BUILD) begin
          state_d = S_BUILD;
        end else begin
          state_d = S_RD_TOP;
        end
      end
      S_INC_KEY: begin
        op_o    = ihp_pkg::OP_INC_KEY;
        state_d = st_i.inc_smaller ? S_RD_TOP : S_SU;
      end
      S_SU: begin
        op_o    = ihp_pkg::OP_SU;
        state_d = st_i.node_zero ? S_WRM : S_SU_C;
      end
      S_SU_C: begin
        op_o    = ihp_pkg::OP_SU_C;
        state_d = st_i.su_move ? S_SU : S_RD_TOP;
      end
      S_WRM: begin
        op_o    = ihp_pkg::OP_WR_MOV;
        state_d = S_RD_TOP;
      end
      S_RD_TOP: begin
        op_o    = ihp_pkg::OP_RD_TOP;
        state_d = S_FIN;
      end
      S_FIN: begin
        op_o = ihp_pkg::OP_FIN;
        if (st_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ihp_dp.sv =====
`timescale 1ns / 1ps
module ihp_dp #(
  parameter int CAPACITY = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ihp_pkg::op_e                        op_i,
  output ihp_pkg::st_t                        st_o,
  input  logic [1:0]                          req_type_i,
  input  logic [ihp_pkg::VTX_W-1:0]           vertex_i,
  input  logic signed [ihp_pkg::KEY_W-1:0]    key_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [1:0]                          status_o,
  output logic [ihp_pkg::VTX_W-1:0]           top_vertex_o,
  output logic [ihp_pkg::COUNT_W-1:0]         count_o,
  output logic                                empty_res_o
);

  localparam int SW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int XW     = SW + 2;
  localparam int SLOT_W = $bits(ihp_pkg::slot_t);
  localparam int PW     = $clog2(ihp_pkg::NUM_VTX);

  ihp_pkg::req_e                   req_q, req_d;
  logic [ihp_pkg::VTX_W-1:0]       vtx_q, vtx_d;
  logic signed [ihp_pkg::KEY_W-1:0] key_q, key_d;
  logic [1:0]                      status_q, status_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   i_q, i_d;
  logic [SW-1:0]                   node_q, node_d;
  logic [SW-1:0]                   pos_q, pos_d;
  ihp_pkg::slot_t                  mov_q, mov_d;
  ihp_pkg::slot_t                  lchild_q, lchild_d;
  logic [ihp_pkg::VTX_W-1:0]       top_q, top_d;
  logic                            top_set_q, top_set_d;
  logic [ihp_pkg::NUM_VTX-1:0]     valid_q, valid_d;

  logic                            out_v_q, out_v_d;
  logic [1:0]                      out_status_q, out_status_d;
  logic [ihp_pkg::VTX_W-1:0]       out_top_q, out_top_d;
  logic [ihp_pkg::COUNT_W-1:0]     out_count_q, out_count_d;
  logic                            out_empty_q, out_empty_d;

  logic                            s_we, s_re;
  logic [SW-1:0]                   s_waddr, s_raddr;
  ihp_pkg::slot_t                  s_wdata;
  logic [SLOT_W-1:0]               s_rdata;
  ihp_pkg::slot_t                  rslot;
  logic                            p_we, p_re;
  logic [PW-1:0]                   p_waddr, p_raddr;
  logic [SW-1:0]                   p_wdata, p_rdata;

  logic [XW-1:0]                   l_x, r_x, cnt_x;
  logic                            l_ok, r_ok, take_l, take_r;
  logic signed [ihp_pkg::KEY_W-1:0] best_key;
  ihp_pkg::slot_t                  child;
  logic [SW-1:0]                   big_idx, p_idx;
  logic                            out_free;

  ihp_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  ihp_ram #(.WIDTH(SW), .DEPTH(ihp_pkg::NUM_VTX)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign rslot = ihp_pkg::slot_t'(s_rdata);

  // Child and parent indexes of the current node
  assign l_x   = XW'({node_q, 1'b1});
  assign r_x   = l_x + XW'(1);
  assign cnt_x = XW'(count_q);
  assign l_ok  = l_x < cnt_x;
  assign r_ok  = r_x < cnt_x;
  assign p_idx = (node_q - SW'(1)) >> 1;

  // Pick the largest of node, left child and right child
  assign take_l   = l_ok && (lchild_q.key > mov_q.key);
  assign best_key = take_l ? lchild_q.key : mov_q.key;
  assign take_r   = r_ok && (rslot.key > best_key);
  assign child    = take_r ? rslot : lchild_q;
  assign big_idx  = take_r ? SW'(r_x) : SW'(l_x);

  assign out_free = !out_v_q || out_ready_i;

  // Status toward the controller
  always_comb begin
    st_o.req         = req_q;
    st_o.load_bad    = (count_q >= CW'(CAPACITY)) || valid_q[vtx_q];
    st_o.empty       = (count_q == '0);
    st_o.one         = (count_q == CW'(1));
    st_o.build_left  = (i_q != '0);
    st_o.inc_bad     = !valid_q[vtx_q] || (XW'(p_rdata) >= cnt_x);
    st_o.inc_smaller = rslot.key > key_q;
    st_o.sd_move     = take_l || take_r;
    st_o.node_zero   = (node_q == '0);
    st_o.su_move     = rslot.key < mov_q.key;
    st_o.out_free    = out_free;
  end

  // Execute the operation the controller issues
  always_comb begin
    s_we    = 1'b0;
    s_waddr = node_q;
    s_wdata = mov_q;
    s_re    = 1'b0;
    s_raddr = '0;
    p_we    = 1'b0;
    p_waddr = mov_q.vtx;
    p_wdata = node_q;
    p_re    = 1'b0;
    p_raddr = vertex_i;

    req_d     = req_q;
    vtx_d     = vtx_q;
    key_d     = key_q;
    status_d  = status_q;
    count_d   = count_q;
    i_d       = i_q;
    node_d    = node_q;
    pos_d     = pos_q;
    mov_d     = mov_q;
    lchild_d  = lchild_q;
    top_d     = top_q;
    top_set_d = top_set_q;
    valid_d   = valid_q;

    out_v_d      = out_v_q && !out_ready_i;
    out_status_d = out_status_q;
    out_top_d    = out_top_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;

    case (op_i)
      ihp_pkg::OP_ACCEPT: begin
        req_d     = ihp_pkg::req_e'(req_type_i);
        vtx_d     = vertex_i;
        key_d     = key_i;
        status_d  = ihp_pkg::ST_OK;
        top_set_d = 1'b0;
        i_d       = count_q >> 1;
        p_re      = 1'b1;
      end
      ihp_pkg::OP_LOAD: begin
        if (st_o.load_bad) begin
          status_d = ihp_pkg::ST_BAD;
        end else begin
          s_we           = 1'b1;
          s_waddr        = count_q[SW-1:0];
          s_wdata.key    = key_q;
          s_wdata.vtx    = vtx_q;
          p_we           = 1'b1;
          p_waddr        = vtx_q;
          p_wdata        = count_q[SW-1:0];
          valid_d[vtx_q] = 1'b1;
          count_d        = count_q + CW'(1);
        end
      end
      ihp_pkg::OP_SET_EMPTY: begin
        status_d = ihp_pkg::ST_EMPTY;
      end
      ihp_pkg::OP_RD0: begin
        s_re = 1'b1;
      end
      ihp_pkg::OP_DEL_TOP: begin
        top_d              = rslot.vtx;
        top_set_d          = 1'b1;
        valid_d[rslot.vtx] = 1'b0;
        count_d            = count_q - CW'(1);
        s_re               = 1'b1;
        s_raddr            = SW'(count_q - CW'(1));
        node_d             = '0;
      end
      ihp_pkg::OP_BUILD_STEP: begin
        i_d     = i_q - CW'(1);
        node_d  = SW'(i_q - CW'(1));
        s_re    = 1'b1;
        s_raddr = SW'(i_q - CW'(1));
      end
      ihp_pkg::OP_MOV_RD: begin
        mov_d = rslot;
      end
      ihp_pkg::OP_SD_L: begin
        s_re    = 1'b1;
        s_raddr = SW'(l_x);
      end
      ihp_pkg::OP_SD_R: begin
        lchild_d = rslot;
        s_re     = 1'b1;
        s_raddr  = SW'(r_x);
      end
      ihp_pkg::OP_SD_C: begin
        s_we = 1'b1;
        p_we = 1'b1;
        if (st_o.sd_move) begin
          s_wdata = child;
          p_waddr = child.vtx;
          node_d  = big_idx;
        end
      end
      ihp_pkg::OP_INC_CHK: begin
        if (st_o.inc_bad) begin
          status_d = ihp_pkg::ST_BAD;
        end else begin
          pos_d   = p_rdata;
          s_re    = 1'b1;
          s_raddr = p_rdata;
        end
      end
      ihp_pkg::OP_INC_KEY: begin
        if (st_o.inc_smaller) begin
          status_d = ihp_pkg::ST_SMALLER;
        end else begin
          mov_d.key = key_q;
          mov_d.vtx = vtx_q;
          node_d    = pos_q;
        end
      end
      ihp_pkg::OP_SU: begin
        s_re    = 1'b1;
        s_raddr = p_idx;
      end
      ihp_pkg::OP_SU_C: begin
        s_we = 1'b1;
        p_we = 1'b1;
        if (st_o.su_move) begin
          s_wdata = rslot;
          p_waddr = rslot.vtx;
          node_d  = p_idx;
        end
      end
      ihp_pkg::OP_WR_MOV: begin
        s_we = 1'b1;
        p_we = 1'b1;
      end
      ihp_pkg::OP_RD_TOP: begin
        s_re = 1'b1;
      end
      ihp_pkg::OP_FIN: begin
        if (out_free) begin
          out_v_d      = 1'b1;
          out_status_d = status_q;
          if (top_set_q) begin
            out_top_d = top_q;
          end else if (count_q != '0) begin
            out_top_d = rslot.vtx;
          end else begin
            out_top_d = '0;
          end
          out_count_d = ihp_pkg::COUNT_W'(count_q);
          out_empty_d = (count_q == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    vtx_q        <= vtx_d;
    key_q        <= key_d;
    status_q     <= status_d;
    i_q          <= i_d;
    node_q       <= node_d;
    pos_q        <= pos_d;
    mov_q        <= mov_d;
    lchild_q     <= lchild_d;
    top_q        <= top_d;
    top_set_q    <= top_set_d;
    out_status_q <= out_status_d;
    out_top_q    <= out_top_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign out_valid_o  = out_v_q;
  assign status_o     = out_status_q;
  assign top_vertex_o = out_top_q;
  assign count_o      = out_count_q;
  assign empty_res_o  = out_empty_q;

endmodule

// ===== sv/indexed_max_heap_top.sv =====
`timescale 1ns / 1ps
// Indexed binary max-heap of (key, vertex) pairs with a vertex-to-slot map. One request is
// in work at a time; each gives one result, held in an output register so the next request
// is taken while that result waits. All heap slots sit in one single-port-read RAM, so the
// time per request is set by its reads: a delete sifts down from the root, an increase-key
// sifts up from the vertex's slot, and a build sifts down each of the count/2 internal nodes.
// A request waits in its final state for as long as the previous result has not been taken.
module indexed_max_heap_top #(
  parameter int CAPACITY = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ihp_req_if.sink    req_i,
  ihp_res_if.source  res_o
);

  `include "indexed_max_heap_top_assert.svh"

  ihp_pkg::op_e op;
  ihp_pkg::st_t st;

  ihp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .st_i       (st),
    .op_o       (op)
  );

  ihp_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .st_o         (st),
    .req_type_i   (req_i.req_type),
    .vertex_i     (req_i.vertex),
    .key_i        (req_i.key),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .status_o     (res_o.status),
    .top_vertex_o (res_o.top_vertex),
    .count_o      (res_o.count),
    .empty_res_o  (res_o.empty_res)
  );

  // One request in work at a time
  `IHP_ASSERT_NEXT(a_one_in_work, req_i.valid && req_i.ready, !req_i.ready, "request overlap")
  // A delete on an empty heap reports an empty heap
  `IHP_ASSERT_NOW(a_empty_status, res_o.valid && res_o.status == ihp_pkg::ST_EMPTY, res_o.empty_res && res_o.count == '0, "empty status mismatch")
  // A smaller-key result implies a non-empty heap
  `IHP_ASSERT_NOW(a_smaller_nonempty, res_o.valid && res_o.status == ihp_pkg::ST_SMALLER, !res_o.empty_res, "smaller key on empty heap")

endmodule
